/* rtl/cmnc_pkg.sv */
// Package for the coplanar mesh normal check.
// Holds the widths, reset values, register indexes, multiplier selects and the
// command and status structs shared by the controller, datapath and top level.
`default_nettype none

package cmnc_pkg;

  localparam int MAX_TRIANGLES_DEF = 1024;
  localparam int CFG_W             = 32;
  localparam int CFG_IDX_W         = 1;
  localparam int LIMIT_W           = 11;

  localparam logic [CFG_W-1:0]   COS_THRESHOLD_RST  = 32'd966367642;
  localparam logic [LIMIT_W-1:0] TRIANGLE_LIMIT_RST = 11'd400;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_LIMIT = 1'd1;

  localparam logic [3:0] MS_C0   = 4'd0;
  localparam logic [3:0] MS_C1   = 4'd1;
  localparam logic [3:0] MS_C2   = 4'd2;
  localparam logic [3:0] MS_C3   = 4'd3;
  localparam logic [3:0] MS_C4   = 4'd4;
  localparam logic [3:0] MS_C5   = 4'd5;
  localparam logic [3:0] MS_SQ0  = 4'd6;
  localparam logic [3:0] MS_SQ1  = 4'd7;
  localparam logic [3:0] MS_SQ2  = 4'd8;
  localparam logic [3:0] MS_DOT0 = 4'd9;
  localparam logic [3:0] MS_DOT1 = 4'd10;
  localparam logic [3:0] MS_DOT2 = 4'd11;

  typedef struct packed {
    logic       capture;
    logic       edge_calc;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       mag_load;
    logic       mag_final;
    logic       norm_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_point;
    logic       div_step;
    logic       n_store;
    logic       tri_update;
    logic       dot_check;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_vec;
    logic norm_done;
    logic dot_needed;
    logic failed;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/coplanar_mesh_normal_check.sv */
// Coplanar mesh normal check, top level: a controller and a datapath.
// Triangles are taken one at a time: the next is accepted only after the last is through the
// 32-step square root and 32-step divider lanes, which degenerate triangles skip. For the last
// triangle of a mesh that has not failed, the mean normal and the point divide follow before
// out_valid rises. A second result waiting behind an unaccepted one holds off input.
// Reset: synchronous active-high rst clears the mesh state and loads defaults.
`default_nettype none

module coplanar_mesh_normal_check #(
  parameter int MAX_TRIANGLES = cmnc_pkg::MAX_TRIANGLES_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [cmnc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [cmnc_pkg::CFG_W-1:0]      cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [31:0]              v0_x,
  input  wire signed [31:0]              v0_y,
  input  wire signed [31:0]              v0_z,
  input  wire signed [31:0]              v1_x,
  input  wire signed [31:0]              v1_y,
  input  wire signed [31:0]              v1_z,
  input  wire signed [31:0]              v2_x,
  input  wire signed [31:0]              v2_y,
  input  wire signed [31:0]              v2_z,
  input  wire                            last_triangle,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           one_sided,
  output logic signed [31:0]             normal_x,
  output logic signed [31:0]             normal_y,
  output logic signed [31:0]             normal_z,
  output logic signed [31:0]             point_x,
  output logic signed [31:0]             point_y,
  output logic signed [31:0]             point_z
);
  import cmnc_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           st;
  logic [31:0]        vin [9];
  logic signed [31:0] normal_o [3];
  logic signed [31:0] point_o [3];

  assign vin[0] = v0_x;
  assign vin[1] = v0_y;
  assign vin[2] = v0_z;
  assign vin[3] = v1_x;
  assign vin[4] = v1_y;
  assign vin[5] = v1_z;
  assign vin[6] = v2_x;
  assign vin[7] = v2_y;
  assign vin[8] = v2_z;

  assign normal_x = normal_o[0];
  assign normal_y = normal_o[1];
  assign normal_z = normal_o[2];
  assign point_x  = point_o[0];
  assign point_y  = point_o[1];
  assign point_z  = point_o[2];

  cmnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  cmnc_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vin       (vin),
    .last_in   (last_triangle),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .one_sided (one_sided),
    .normal_o  (normal_o),
    .point_o   (point_o)
  );

endmodule

`default_nettype wire

/* rtl/cmnc_ctrl.sv */
// Sequencing state machine for the coplanar mesh normal check.
// Drives the datapath through command and status structs from cmnc_pkg.
`default_nettype none

module cmnc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               out_ready,
  input  cmnc_pkg::dp_stat_t st,
  output cmnc_pkg::dp_cmd_t  cmd
);
  import cmnc_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_EDGE   = 5'd1;
  localparam logic [4:0] ST_CROSS  = 5'd2;
  localparam logic [4:0] ST_MAG    = 5'd3;
  localparam logic [4:0] ST_NORM   = 5'd4;
  localparam logic [4:0] ST_SQ     = 5'd5;
  localparam logic [4:0] ST_SQRTI  = 5'd6;
  localparam logic [4:0] ST_SQRT   = 5'd7;
  localparam logic [4:0] ST_DIVI   = 5'd8;
  localparam logic [4:0] ST_DIV    = 5'd9;
  localparam logic [4:0] ST_NSTORE = 5'd10;
  localparam logic [4:0] ST_UPDATE = 5'd11;
  localparam logic [4:0] ST_DOT    = 5'd12;
  localparam logic [4:0] ST_CHECK  = 5'd13;
  localparam logic [4:0] ST_FINAL  = 5'd14;
  localparam logic [4:0] ST_PDIVI  = 5'd15;
  localparam logic [4:0] ST_PDIV   = 5'd16;
  localparam logic [4:0] ST_OUT    = 5'd17;

  logic [4:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       fin, fin_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    fin_next   = fin;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.edge_calc = 1'b1;
        cnt_next      = 6'd0;
        state_next    = ST_CROSS;
      end
      ST_CROSS: begin
        if (cnt < 6'd6) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_C0 + cnt[3:0];
          cnt_next    = cnt + 6'd1;
        end else begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag_load  = 1'b1;
        cmd.mag_final = fin;
        state_next    = ST_NORM;
      end
      ST_NORM: begin
        if (st.zero_vec) begin
          state_next = ST_NSTORE;
        end else if (st.norm_done) begin
          cnt_next   = 6'd0;
          state_next = ST_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQ: begin
        if (cnt < 6'd3) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_SQ0 + cnt[3:0];
          cnt_next    = cnt + 6'd1;
        end else begin
          state_next = ST_SQRTI;
        end
      end
      ST_SQRTI: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = 6'd0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 6'd1;
        if (cnt == 6'd31) begin
          state_next = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = 6'd0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == 6'd31) begin
          state_next = ST_NSTORE;
        end
      end
      ST_NSTORE: begin
        cmd.n_store = 1'b1;
        state_next  = fin ? ST_PDIVI : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.tri_update = 1'b1;
        cnt_next       = 6'd0;
        if (st.dot_needed) begin
          state_next = ST_DOT;
        end else begin
          state_next = st.last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_DOT: begin
        if (cnt < 6'd3) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_DOT0 + cnt[3:0];
          cnt_next    = cnt + 6'd1;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.dot_check = 1'b1;
        state_next    = st.last ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        if (st.failed) begin
          state_next = ST_OUT;
        end else begin
          fin_next   = 1'b1;
          state_next = ST_MAG;
        end
      end
      ST_PDIVI: begin
        cmd.div_init  = 1'b1;
        cmd.div_point = 1'b1;
        cnt_next      = 6'd0;
        state_next    = ST_PDIV;
      end
      ST_PDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == 6'd31) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!st.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          fin_next     = 1'b0;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 6'd0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      fin   <= fin_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cmnc_dp.sv */
// Datapath for the coplanar mesh normal check: edges, shared multiplier,
// normalizer, square root, three divider lanes, mesh state and result registers.
// Depends on cmnc_pkg for widths, codes and the command and status structs.
`default_nettype none

module cmnc_dp #(
  parameter int MAX_TRIANGLES = cmnc_pkg::MAX_TRIANGLES_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  cmnc_pkg::dp_cmd_t                  cmd,
  output cmnc_pkg::dp_stat_t                 st,
  input  wire                               cfg_we,
  input  wire [cmnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [cmnc_pkg::CFG_W-1:0]         cfg_data,
  input  wire [31:0]                        vin [9],
  input  wire                               last_in,
  input  wire                               out_ready,
  output logic                              out_valid,
  output logic                              one_sided,
  output logic signed [31:0]                normal_o [3],
  output logic signed [31:0]                point_o [3]
);
  import cmnc_pkg::*;

  localparam int CNT_W = $clog2(MAX_TRIANGLES + 2);
  localparam int SUM_W = 32 + $clog2(MAX_TRIANGLES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRIANGLES);

  logic signed [CFG_W-1:0]   thr;
  logic        [LIMIT_W-1:0] limit;

  logic [31:0]        v [9];
  logic               last;
  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [61:0] c [3];
  logic        [61:0] m [3];
  logic               neg [3];
  logic signed [63:0] prod;
  logic        [3:0]  prod_sel;
  logic               prod_vld;
  logic        [63:0] sq;
  logic signed [63:0] dot;
  logic        [63:0] sx, sr, sb;
  logic        [31:0] rem [3];
  logic        [31:0] lo [3];
  logic        [31:0] quo [3];
  logic        [31:0] dv;
  logic signed [31:0] n [3];
  logic signed [31:0] first_normal [3];
  logic signed [SUM_W-1:0] nsum [3];
  logic signed [SUM_W-1:0] psum [3];
  logic        [CNT_W-1:0] count;
  logic               failed;

  logic signed [32:0] d1 [3];
  logic signed [32:0] d2 [3];
  logic        [32:0] a1 [3];
  logic        [32:0] a2 [3];
  logic        [32:0] eor;
  logic        [1:0]  esh;
  logic signed [31:0] ma, mb;
  logic        [61:0] mor;
  logic        [63:0] st_t;
  logic               st_ge;
  logic        [CNT_W-1:0] count_inc;
  logic               fail_next;
  logic signed [63:0] thr64;
  logic signed [61:0] msrc [3];
  logic        [SUM_W-1:0] pmag [3];
  logic        [32:0] dt [3];
  logic               dge [3];

  always_comb begin
    eor = '0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed({v[3+i][31], v[3+i]}) - $signed({v[i][31], v[i]});
      d2[i] = $signed({v[6+i][31], v[6+i]}) - $signed({v[i][31], v[i]});
      a1[i] = d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
      a2[i] = d2[i][32] ? 33'(-d2[i]) : 33'(d2[i]);
      eor   = eor | a1[i] | a2[i];
    end
    if (eor[32]) begin
      esh = 2'd3;
    end else if (eor[31]) begin
      esh = 2'd2;
    end else if (eor[30]) begin
      esh = 2'd1;
    end else begin
      esh = 2'd0;
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_C0:   begin ma = e2[1]; mb = e1[2]; end
      MS_C1:   begin ma = e2[2]; mb = e1[1]; end
      MS_C2:   begin ma = e2[2]; mb = e1[0]; end
      MS_C3:   begin ma = e2[0]; mb = e1[2]; end
      MS_C4:   begin ma = e2[0]; mb = e1[1]; end
      MS_C5:   begin ma = e2[1]; mb = e1[0]; end
      MS_SQ0:  begin ma = $signed(m[0][31:0]); mb = $signed(m[0][31:0]); end
      MS_SQ1:  begin ma = $signed(m[1][31:0]); mb = $signed(m[1][31:0]); end
      MS_SQ2:  begin ma = $signed(m[2][31:0]); mb = $signed(m[2][31:0]); end
      MS_DOT0: begin ma = first_normal[0]; mb = n[0]; end
      MS_DOT1: begin ma = first_normal[1]; mb = n[1]; end
      MS_DOT2: begin ma = first_normal[2]; mb = n[2]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    mor   = m[0] | m[1] | m[2];
    st_t  = sr + sb;
    st_ge = sx >= st_t;
    count_inc = (count <= MAX_CNT) ? count + CNT_W'(1) : count;
    fail_next = failed || (32'(count_inc) > 32'(MAX_TRIANGLES))
                       || (32'(count_inc) > 32'(limit));
    thr64 = $signed({{2{thr[31]}}, thr, 30'b0});
    for (int i = 0; i < 3; i++) begin
      msrc[i] = cmd.mag_final ? 62'(nsum[i]) : c[i];
      pmag[i] = psum[i][SUM_W-1] ? SUM_W'(-psum[i]) : SUM_W'(psum[i]);
      dt[i]   = {rem[i], lo[i][31]};
      dge[i]  = dt[i] >= {1'b0, dv};
    end
  end

  always_comb begin
    st.zero_vec   = (mor == '0);
    st.norm_done  = (mor[61:31] == '0) && mor[30];
    st.dot_needed = !fail_next && (count_inc != CNT_W'(1));
    st.failed     = failed;
    st.last       = last;
    st.out_busy   = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 9; i++) begin
        v[i] <= vin[i];
      end
      last <= last_in;
    end
    if (cmd.edge_calc) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= d1[i][32] ? -$signed(32'(a1[i] >> esh)) : $signed(32'(a1[i] >> esh));
        e2[i] <= d2[i][32] ? -$signed(32'(a2[i] >> esh)) : $signed(32'(a2[i] >> esh));
      end
    end
    prod     <= ma * mb;
    prod_sel <= cmd.mul_sel;
    if (prod_vld) begin
      case (prod_sel)
        MS_C0:   c[0] <= prod[61:0];
        MS_C1:   c[0] <= c[0] - $signed(prod[61:0]);
        MS_C2:   c[1] <= prod[61:0];
        MS_C3:   c[1] <= c[1] - $signed(prod[61:0]);
        MS_C4:   c[2] <= prod[61:0];
        MS_C5:   c[2] <= c[2] - $signed(prod[61:0]);
        MS_SQ0:  sq <= prod;
        MS_SQ1:  sq <= sq + prod;
        MS_SQ2:  sq <= sq + prod;
        MS_DOT0: dot <= prod;
        MS_DOT1: dot <= dot + prod;
        MS_DOT2: dot <= dot + prod;
        default: ;
      endcase
    end
    if (cmd.mag_load) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= msrc[i][61];
        m[i]   <= msrc[i][61] ? 62'(-msrc[i]) : 62'(msrc[i]);
      end
    end else if (cmd.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        if (mor[61:39] != '0) begin
          m[i] <= m[i] >> 8;
        end else if (mor[61:31] != '0) begin
          m[i] <= m[i] >> 1;
        end else if (mor[30:22] == '0) begin
          m[i] <= m[i] << 8;
        end else begin
          m[i] <= m[i] << 1;
        end
      end
    end
    if (cmd.sqrt_init) begin
      sx <= sq;
      sr <= '0;
      sb <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (st_ge) begin
        sx <= sx - st_t;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end
    if (cmd.div_init) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.div_point) begin
          {rem[i], lo[i]} <= 64'(pmag[i]) + 64'(count >> 1);
        end else begin
          {rem[i], lo[i]} <= 64'({m[i][30:0], 30'b0}) + 64'(sr[31:1]);
        end
      end
      dv <= cmd.div_point ? 32'(count) : sr[31:0];
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= dge[i] ? 32'(dt[i] - {1'b0, dv}) : dt[i][31:0];
        lo[i]  <= lo[i] << 1;
        quo[i] <= {quo[i][30:0], dge[i]};
      end
    end
    if (cmd.n_store) begin
      for (int i = 0; i < 3; i++) begin
        if (st.zero_vec) begin
          n[i] <= '0;
        end else begin
          n[i] <= neg[i] ? -$signed(quo[i]) : $signed(quo[i]);
        end
      end
    end
    if (cmd.out_load) begin
      one_sided <= !failed;
      for (int i = 0; i < 3; i++) begin
        if (failed) begin
          normal_o[i] <= '0;
          point_o[i]  <= '0;
        end else begin
          normal_o[i] <= n[i];
          point_o[i]  <= psum[i][SUM_W-1] ? -$signed(quo[i]) : $signed(quo[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= COS_THRESHOLD_RST;
      limit     <= TRIANGLE_LIMIT_RST;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      failed    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_normal[i] <= '0;
        nsum[i]         <= '0;
        psum[i]         <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COS_THRESHOLD:  thr   <= cfg_data;
          CFG_TRIANGLE_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      prod_vld <= cmd.mul_en;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        count  <= '0;
        failed <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          first_normal[i] <= '0;
          nsum[i]         <= '0;
          psum[i]         <= '0;
        end
      end else if (cmd.tri_update) begin
        count  <= count_inc;
        failed <= fail_next;
        if (!fail_next && (count_inc == CNT_W'(1))) begin
          for (int i = 0; i < 3; i++) begin
            first_normal[i] <= n[i];
            nsum[i]         <= SUM_W'(n[i]);
            psum[i]         <= SUM_W'($signed(v[i]));
          end
        end
      end else if (cmd.dot_check) begin
        if (dot < thr64) begin
          failed <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            nsum[i] <= nsum[i] + SUM_W'(n[i]);
            psum[i] <= psum[i] + SUM_W'($signed(v[i]));
          end
        end
      end
    end
  end

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while an item waits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_TRIANGLES) + 32'd1)
    else $error("triangle count beyond saturation");

  a_unit_quotient: assert property (@(posedge clk) disable iff (rst)
    (cmd.n_store && !st.zero_vec) |->
      (quo[0] <= 32'h4000_0000 && quo[1] <= 32'h4000_0000 && quo[2] <= 32'h4000_0000))
    else $error("unit normal component above one");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && failed) |=> (!one_sided && normal_o[0] == '0 && point_o[0] == '0))
    else $error("failed mesh result not cleared");

endmodule

`default_nettype wire
